>>> rtl/lbc_pkg.sv
// ----------------------------------------------------------------------------
// lbc_pkg
// Shared widths, codes and state type for the LRU block buffer cache.
// ----------------------------------------------------------------------------
`default_nettype none

package lbc_pkg;

   // Default geometry of the cache.
   localparam int LBC_ENTRIES     = 16;
   localparam int LBC_DEVICE_BITS = 8;
   localparam int LBC_SECTOR_BITS = 32;

   // Fixed field widths of the request and response channels.
   localparam int MODE_W   = 2;
   localparam int DEVICE_W = 8;
   localparam int SECTOR_W = 32;
   localparam int SLOT_W   = 4;
   localparam int DISK_W   = 2;
   localparam int STATUS_W = 2;

   // Request modes.
   localparam logic [MODE_W-1:0] MODE_GET      = 2'd0;
   localparam logic [MODE_W-1:0] MODE_RELEASE  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_WRITE    = 2'd2;
   localparam logic [MODE_W-1:0] MODE_COMPLETE = 2'd3;

   // Disk transfer requests.
   localparam logic [DISK_W-1:0] DISK_NONE  = 2'd0;
   localparam logic [DISK_W-1:0] DISK_READ  = 2'd1;
   localparam logic [DISK_W-1:0] DISK_WRITE = 2'd2;

   // Response status codes.
   localparam logic [STATUS_W-1:0] STAT_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_RETRY    = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_NOBUF    = 2'd2;
   localparam logic [STATUS_W-1:0] STAT_NOTBUSY  = 2'd3;

   typedef enum logic [2:0] {
      STATE_INIT,
      STATE_IDLE,
      STATE_SEARCH,
      STATE_MOVE,
      STATE_RESP
   } state_type;

endpackage

`default_nettype wire

>>> rtl/lbc_req_if.sv
// ----------------------------------------------------------------------------
// lbc_req_if
// Request channel of the buffer cache: valid/ready handshake and payload.
// ----------------------------------------------------------------------------
`default_nettype none

interface lbc_req_if;
   logic                          valid;
   logic                          ready;
   logic [lbc_pkg::MODE_W-1:0]    mode;
   logic [lbc_pkg::DEVICE_W-1:0]  device;
   logic [lbc_pkg::SECTOR_W-1:0]  sector;
   logic [lbc_pkg::SLOT_W-1:0]    slot;

   modport source (output valid, output mode, output device, output sector,
                   output slot, input ready);
   modport sink   (input valid, input mode, input device, input sector,
                   input slot, output ready);
endinterface

`default_nettype wire

>>> rtl/lbc_rsp_if.sv
// ----------------------------------------------------------------------------
// lbc_rsp_if
// Response channel of the buffer cache: valid/ready handshake and payload.
// ----------------------------------------------------------------------------
`default_nettype none

interface lbc_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [lbc_pkg::SLOT_W-1:0]    slot_out;
   logic                          hit;
   logic [lbc_pkg::DISK_W-1:0]    disk_request;
   logic [lbc_pkg::STATUS_W-1:0]  status;

   modport source (output valid, output slot_out, output hit,
                   output disk_request, output status, input ready);
   modport sink   (input valid, input slot_out, input hit,
                   input disk_request, input status, output ready);
endinterface

`default_nettype wire

>>> rtl/lru_block_buffer_cache.sv
// ----------------------------------------------------------------------------
// lru_block_buffer_cache
// Buffer cache controller: tags of disk-sector buffers with busy, valid and
// dirty marks and a least-recently-used order kept in a memory.
//
// Usage:
//   Requests enter on req_ch (valid/ready); each request yields exactly one
//   response on rsp_ch (valid/ready), in order. One request is worked on at
//   a time.
//   A get walks the recency order one position per cycle through the order
//   memory and the tag memory, two read stages deep, and stops at the
//   first hit or after the last position.
//   A release rewrites the order memory from the front down to the slot's
//   position p, one entry per cycle. Write and completion answer after 1
//   cycle. The next request is taken in the cycle after the response is
//   loaded into the output register.
//   After reset the order memory is initialized first, and no request is
//   taken until it is done; all marks are cleared at once.
//   When the receiver stalls, the response waits in the output register and
//   the block still takes and works on the next request; that request's
//   response waits until the output register is free.
// ----------------------------------------------------------------------------
`default_nettype none

module lru_block_buffer_cache #(
   parameter int ENTRIES     = lbc_pkg::LBC_ENTRIES,
   parameter int DEVICE_BITS = lbc_pkg::LBC_DEVICE_BITS,
   parameter int SECTOR_BITS = lbc_pkg::LBC_SECTOR_BITS
) (
   input  logic       clock,
   input  logic       reset,
   lbc_req_if.sink    req_ch,
   lbc_rsp_if.source  rsp_ch
);

   import lbc_pkg::*;

   localparam int IDX_W = $clog2(ENTRIES);
   localparam int POS_W = IDX_W + 1;
   localparam int TAG_W = DEVICE_BITS + SECTOR_BITS;

   // Control state.
   state_type         state_ff, state_in;
   logic [IDX_W-1:0]  init_cnt_ff, init_cnt_in;
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic              s1_vld_ff, s1_vld_in;
   logic              s1_last_ff, s1_last_in;
   logic              s2_vld_ff, s2_vld_in;
   logic              s2_last_ff, s2_last_in;
   logic              vic_found_ff, vic_found_in;
   logic              pend_ff, pend_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [ENTRIES-1:0] used_ff, used_in;
   logic [ENTRIES-1:0] busy_ff, busy_in;
   logic [ENTRIES-1:0] valid_ff, valid_in;
   logic [ENTRIES-1:0] dirty_ff, dirty_in;

   // Payload state.
   logic [IDX_W-1:0]    s2_slot_ff, s2_slot_in;
   logic [IDX_W-1:0]    vic_ff, vic_in;
   logic [IDX_W-1:0]    target_ff, target_in;
   logic [IDX_W-1:0]    carry_ff, carry_in;
   logic [TAG_W-1:0]    key_ff, key_in;
   logic [SLOT_W-1:0]   res_slot_ff, res_slot_in;
   logic                res_hit_ff, res_hit_in;
   logic [DISK_W-1:0]   res_disk_ff, res_disk_in;
   logic [STATUS_W-1:0] res_status_ff, res_status_in;
   logic [SLOT_W-1:0]   rsp_slot_ff;
   logic                rsp_hit_ff;
   logic [DISK_W-1:0]   rsp_disk_ff;
   logic [STATUS_W-1:0] rsp_status_ff;

   // Recency order memory: position 0 is the most recent slot.
   logic [IDX_W-1:0] order_mem [ENTRIES];
   logic [IDX_W-1:0] order_q_ff;
   logic             ord_we;
   logic [IDX_W-1:0] ord_waddr;
   logic [IDX_W-1:0] ord_wdata;
   logic [IDX_W-1:0] ord_raddr;

   logic             tag_we;
   logic             tag_match;
   logic             load_rsp;
   logic             req_ready;

   logic [31:0]      dev_wide;
   logic [7:0]       slot_wide;
   logic             slot_beyond;
   logic [IDX_W-1:0] slot_idx;
   logic [POS_W-1:0] pos_next;
   logic             s2_hit;

   assign dev_wide    = 32'(req_ch.device);
   assign slot_wide   = 8'(req_ch.slot);
   assign slot_beyond = (slot_wide >= 8'(ENTRIES));
   assign slot_idx    = slot_wide[IDX_W-1:0];
   assign pos_next    = pos_ff + POS_W'(1);
   assign s2_hit      = s2_vld_ff && used_ff[s2_slot_ff] && tag_match;

   lbc_tag_store #(
      .ENTRIES (ENTRIES),
      .TAG_W   (TAG_W)
   ) u_tag_store (
      .clock   (clock),
      .wr_en   (tag_we),
      .wr_addr (vic_ff),
      .wr_tag  (key_ff),
      .rd_addr (order_q_ff),
      .key     (key_ff),
      .match   (tag_match)
   );

   always_ff @(posedge clock) begin
      if (ord_we) begin
         order_mem[ord_waddr] <= ord_wdata;
      end
      order_q_ff <= order_mem[ord_raddr];
   end

   always_comb begin
      state_in      = state_ff;
      init_cnt_in   = init_cnt_ff;
      pos_in        = pos_ff;
      s1_vld_in     = 1'b0;
      s1_last_in    = s1_last_ff;
      s2_vld_in     = 1'b0;
      s2_last_in    = s2_last_ff;
      s2_slot_in    = s2_slot_ff;
      vic_found_in  = vic_found_ff;
      vic_in        = vic_ff;
      pend_in       = pend_ff;
      target_in     = target_ff;
      carry_in      = carry_ff;
      key_in        = key_ff;
      used_in       = used_ff;
      busy_in       = busy_ff;
      valid_in      = valid_ff;
      dirty_in      = dirty_ff;
      res_slot_in   = res_slot_ff;
      res_hit_in    = res_hit_ff;
      res_disk_in   = res_disk_ff;
      res_status_in = res_status_ff;
      ord_we        = 1'b0;
      ord_waddr     = pos_ff[IDX_W-1:0];
      ord_wdata     = carry_ff;
      ord_raddr     = pos_ff[IDX_W-1:0];
      tag_we        = 1'b0;
      load_rsp      = 1'b0;
      req_ready     = 1'b0;

      unique case (state_ff)
         STATE_INIT: begin
            ord_we      = 1'b1;
            ord_waddr   = init_cnt_ff;
            ord_wdata   = IDX_W'(ENTRIES - 1) - init_cnt_ff;
            init_cnt_in = init_cnt_ff + IDX_W'(1);
            if (init_cnt_ff == IDX_W'(ENTRIES - 1)) begin
               state_in = STATE_IDLE;
            end
         end

         STATE_IDLE: begin
            req_ready = 1'b1;
            if (req_ch.valid) begin
               key_in        = {dev_wide[DEVICE_BITS-1:0], req_ch.sector[SECTOR_BITS-1:0]};
               pos_in        = '0;
               vic_found_in  = 1'b0;
               pend_in       = 1'b0;
               res_slot_in   = req_ch.slot;
               res_hit_in    = 1'b0;
               res_disk_in   = DISK_NONE;
               res_status_in = STAT_NOTBUSY;
               priority if (req_ch.mode == MODE_GET) begin
                  state_in = STATE_SEARCH;
               end else if (slot_beyond) begin
                  state_in = STATE_RESP;
               end else if (req_ch.mode == MODE_RELEASE) begin
                  if (busy_ff[slot_idx]) begin
                     target_in = slot_idx;
                     carry_in  = slot_idx;
                     state_in  = STATE_MOVE;
                  end else begin
                     state_in = STATE_RESP;
                  end
               end else if (req_ch.mode == MODE_WRITE) begin
                  if (busy_ff[slot_idx]) begin
                     dirty_in[slot_idx] = 1'b1;
                     res_disk_in        = DISK_WRITE;
                     res_status_in      = STAT_OK;
                  end
                  state_in = STATE_RESP;
               end else begin
                  valid_in[slot_idx] = 1'b1;
                  dirty_in[slot_idx] = 1'b0;
                  res_status_in      = STAT_OK;
                  state_in           = STATE_RESP;
               end
            end
         end

         STATE_SEARCH: begin
            // Stage 0: read the slot held at the next position.
            if (pos_ff < POS_W'(ENTRIES)) begin
               s1_vld_in  = 1'b1;
               s1_last_in = (pos_ff == POS_W'(ENTRIES - 1));
               pos_in     = pos_next;
            end
            // Stage 1: read that slot's tag; the last free and clean slot
            // seen is the least recent one and becomes the victim.
            s2_vld_in  = s1_vld_ff;
            s2_slot_in = order_q_ff;
            s2_last_in = s1_last_ff;
            if (s1_vld_ff && !busy_ff[order_q_ff] && !dirty_ff[order_q_ff]) begin
               vic_in       = order_q_ff;
               vic_found_in = 1'b1;
            end
            // Stage 2: compare the tag.
            if (s2_hit) begin
               res_slot_in = SLOT_W'(s2_slot_ff);
               res_hit_in  = 1'b1;
               if (busy_ff[s2_slot_ff]) begin
                  res_disk_in   = DISK_NONE;
                  res_status_in = STAT_RETRY;
               end else begin
                  busy_in[s2_slot_ff] = 1'b1;
                  res_disk_in   = valid_ff[s2_slot_ff] ? DISK_NONE : DISK_READ;
                  res_status_in = STAT_OK;
               end
               s1_vld_in = 1'b0;
               s2_vld_in = 1'b0;
               state_in  = STATE_RESP;
            end else if (s2_vld_ff && s2_last_ff) begin
               res_hit_in = 1'b0;
               if (vic_found_ff) begin
                  tag_we           = 1'b1;
                  used_in[vic_ff]  = 1'b1;
                  busy_in[vic_ff]  = 1'b1;
                  valid_in[vic_ff] = 1'b0;
                  dirty_in[vic_ff] = 1'b0;
                  res_slot_in      = SLOT_W'(vic_ff);
                  res_disk_in      = DISK_READ;
                  res_status_in    = STAT_OK;
               end else begin
                  res_slot_in   = '0;
                  res_disk_in   = DISK_NONE;
                  res_status_in = STAT_NOBUF;
               end
               s1_vld_in = 1'b0;
               s2_vld_in = 1'b0;
               state_in  = STATE_RESP;
            end
         end

         STATE_MOVE: begin
            // Shift each entry one position back until the released slot's
            // old position has been overwritten, then it sits at the front.
            if (!pend_ff) begin
               pend_in = 1'b1;
            end else begin
               ord_we    = 1'b1;
               ord_waddr = pos_ff[IDX_W-1:0];
               ord_wdata = carry_ff;
               carry_in  = order_q_ff;
               if (order_q_ff == target_ff) begin
                  busy_in[target_ff] = 1'b0;
                  res_status_in      = STAT_OK;
                  pend_in            = 1'b0;
                  state_in           = STATE_RESP;
               end else begin
                  ord_raddr = pos_next[IDX_W-1:0];
                  pos_in    = pos_next;
               end
            end
         end

         STATE_RESP: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               load_rsp = 1'b1;
               state_in = STATE_IDLE;
            end
         end

         default: begin
            state_in = STATE_INIT;
         end
      endcase

      rsp_valid_in = (rsp_valid_ff && !rsp_ch.ready) || load_rsp;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= STATE_INIT;
         init_cnt_ff  <= '0;
         pos_ff       <= '0;
         s1_vld_ff    <= 1'b0;
         s1_last_ff   <= 1'b0;
         s2_vld_ff    <= 1'b0;
         s2_last_ff   <= 1'b0;
         vic_found_ff <= 1'b0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         used_ff      <= '0;
         busy_ff      <= '0;
         valid_ff     <= '0;
         dirty_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         init_cnt_ff  <= init_cnt_in;
         pos_ff       <= pos_in;
         s1_vld_ff    <= s1_vld_in;
         s1_last_ff   <= s1_last_in;
         s2_vld_ff    <= s2_vld_in;
         s2_last_ff   <= s2_last_in;
         vic_found_ff <= vic_found_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
         used_ff      <= used_in;
         busy_ff      <= busy_in;
         valid_ff     <= valid_in;
         dirty_ff     <= dirty_in;
      end
   end

   always_ff @(posedge clock) begin
      s2_slot_ff    <= s2_slot_in;
      vic_ff        <= vic_in;
      target_ff     <= target_in;
      carry_ff      <= carry_in;
      key_ff        <= key_in;
      res_slot_ff   <= res_slot_in;
      res_hit_ff    <= res_hit_in;
      res_disk_ff   <= res_disk_in;
      res_status_ff <= res_status_in;
      if (load_rsp) begin
         rsp_slot_ff   <= res_slot_ff;
         rsp_hit_ff    <= res_hit_ff;
         rsp_disk_ff   <= res_disk_ff;
         rsp_status_ff <= res_status_ff;
      end
   end

   assign req_ch.ready        = req_ready;
   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.slot_out     = rsp_slot_ff;
   assign rsp_ch.hit          = rsp_hit_ff;
   assign rsp_ch.disk_request = rsp_disk_ff;
   assign rsp_ch.status       = rsp_status_ff;

endmodule

`default_nettype wire

>>> rtl/lbc_tag_store.sv
// ----------------------------------------------------------------------------
// lbc_tag_store
// Tag memory holding the device and sector of each slot, with a registered
// read port and a compare of the read tag against the search key.
// ----------------------------------------------------------------------------
`default_nettype none

module lbc_tag_store #(
   parameter int ENTRIES = lbc_pkg::LBC_ENTRIES,
   parameter int TAG_W   = lbc_pkg::LBC_DEVICE_BITS + lbc_pkg::LBC_SECTOR_BITS
) (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [$clog2(ENTRIES)-1:0] wr_addr,
   input  logic [TAG_W-1:0]           wr_tag,
   input  logic [$clog2(ENTRIES)-1:0] rd_addr,
   input  logic [TAG_W-1:0]           key,
   output logic                       match
);

   logic [TAG_W-1:0] tag_mem [ENTRIES];
   logic [TAG_W-1:0] rd_q_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         tag_mem[wr_addr] <= wr_tag;
      end
      rd_q_ff <= tag_mem[rd_addr];
   end

   // The match belongs to the slot that was addressed in the previous cycle.
   assign match = (rd_q_ff == key);

endmodule

`default_nettype wire

>>> rtl/lbc_checker.sv
// ----------------------------------------------------------------------------
// lbc_checker
// Port-level checks of the buffer cache, attached to the top level by bind.
// ----------------------------------------------------------------------------
`default_nettype none

module lbc_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_ready,
   input  logic                          rsp_valid,
   input  logic                          rsp_ready,
   input  logic [lbc_pkg::SLOT_W-1:0]    rsp_slot_out,
   input  logic                          rsp_hit,
   input  logic [lbc_pkg::DISK_W-1:0]    rsp_disk_request,
   input  logic [lbc_pkg::STATUS_W-1:0]  rsp_status
);

   import lbc_pkg::*;

   // The order memory is initialized after reset before any request is taken.
   a_no_accept_after_reset: assert property (@(posedge clock)
      reset |=> !req_ready)
      else $error("request taken right after reset");

   // A stalled response keeps its content.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_slot_out) && $stable(rsp_disk_request))
      else $error("stalled response changed");

   // Only a successful get or write asks for a disk transfer.
   a_disk_only_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != STAT_OK |-> rsp_disk_request == DISK_NONE)
      else $error("disk transfer requested with an error status");

   // A hit is either granted or retried, and never asks for a disk write.
   a_hit_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_hit |-> (rsp_status == STAT_OK || rsp_status == STAT_RETRY)
         && rsp_disk_request != DISK_WRITE)
      else $error("hit with an impossible status");

   // Running out of buffers reports slot zero and no hit.
   a_nobuf_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STAT_NOBUF |-> rsp_slot_out == '0 && !rsp_hit)
      else $error("no-buffer response with a slot or hit");

endmodule

bind lru_block_buffer_cache lbc_checker u_lbc_checker (
   .clock            (clock),
   .reset            (reset),
   .req_ready        (req_ch.ready),
   .rsp_valid        (rsp_ch.valid),
   .rsp_ready        (rsp_ch.ready),
   .rsp_slot_out     (rsp_ch.slot_out),
   .rsp_hit          (rsp_ch.hit),
   .rsp_disk_request (rsp_ch.disk_request),
   .rsp_status       (rsp_ch.status)
);

`default_nettype wire

>>> test/lbc_cache_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbc_cache_checker
// Watches the request and response channels of the buffer cache, keeps its
// own copy of the tags, marks and recency order, and checks every response
// against the answer predicted for the request that caused it.
// ----------------------------------------------------------------------------

module lbc_cache_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic                            req_ready,
   input  logic [lbc_pkg::MODE_W-1:0]      req_mode,
   input  logic [lbc_pkg::DEVICE_W-1:0]    req_device,
   input  logic [lbc_pkg::SECTOR_W-1:0]    req_sector,
   input  logic [lbc_pkg::SLOT_W-1:0]      req_slot,
   input  logic                            rsp_valid,
   input  logic                            rsp_ready,
   input  logic [lbc_pkg::SLOT_W-1:0]      rsp_slot_out,
   input  logic                            rsp_hit,
   input  logic [lbc_pkg::DISK_W-1:0]      rsp_disk_request,
   input  logic [lbc_pkg::STATUS_W-1:0]    rsp_status,
   output int                              fail_count,
   output int                              pending_answers,
   output logic [lbc_pkg::LBC_ENTRIES-1:0] busy_slots,
   output logic [lbc_pkg::LBC_ENTRIES-1:0] dirty_slots
);

   import lbc_pkg::*;

   typedef struct packed {
      logic [SLOT_W-1:0]   slot_out;
      logic                hit;
      logic [DISK_W-1:0]   disk;
      logic [STATUS_W-1:0] status;
   } cache_answer_type;

   // Shadow copy of the cache state.
   logic [LBC_ENTRIES-1:0]     tag_used;
   logic [LBC_ENTRIES-1:0]     valid_slots;
   logic [DEVICE_W-1:0]        tag_device [LBC_ENTRIES];
   logic [SECTOR_W-1:0]        tag_sector [LBC_ENTRIES];
   logic [SLOT_W-1:0]          lru_list [LBC_ENTRIES];

   cache_answer_type expected_answers[$];
   cache_answer_type predicted;
   cache_answer_type observed;

   initial fail_count = 0;

   task automatic clear_cache_state();
      for (int i = 0; i < LBC_ENTRIES; i++) begin
         tag_device[i] = '0;
         tag_sector[i] = '0;
         lru_list[i] = SLOT_W'(LBC_ENTRIES - 1 - i);
      end
      tag_used = '0;
      busy_slots = '0;
      valid_slots = '0;
      dirty_slots = '0;
   endtask

   task automatic move_slot_to_front(input logic [SLOT_W-1:0] s);
      int pos;
      pos = 0;
      for (int i = LBC_ENTRIES - 1; i >= 0; i--) begin
         if (lru_list[i] == s) pos = i;
      end
      for (int i = pos; i > 0; i--) lru_list[i] = lru_list[i - 1];
      lru_list[0] = s;
   endtask

   // Applies one request to the shadow state and returns the answer it earns.
   task automatic predict_answer(input logic [MODE_W-1:0] m,
                                 input logic [DEVICE_W-1:0] dev,
                                 input logic [SECTOR_W-1:0] sec,
                                 input logic [SLOT_W-1:0] sl,
                                 output cache_answer_type ans);
      logic [SLOT_W-1:0] s;
      bit done;
      done = 0;
      ans = '{slot_out: sl, hit: 1'b0, disk: DISK_NONE, status: STAT_OK};
      if (m == MODE_GET) begin
         // Tag search runs from the most recent position down.
         for (int i = 0; i < LBC_ENTRIES; i++) begin
            s = lru_list[i];
            if (!done && tag_used[s] && tag_device[s] == dev && tag_sector[s] == sec) begin
               done = 1;
               ans.slot_out = s;
               ans.hit = 1'b1;
               if (busy_slots[s]) begin
                  ans.status = STAT_RETRY;
               end else begin
                  busy_slots[s] = 1'b1;
                  ans.disk = valid_slots[s] ? DISK_NONE : DISK_READ;
               end
            end
         end
         // On a miss the least recent clean, free slot is recycled.
         for (int i = LBC_ENTRIES - 1; i >= 0; i--) begin
            s = lru_list[i];
            if (!done && !busy_slots[s] && !dirty_slots[s]) begin
               done = 1;
               tag_used[s] = 1'b1;
               tag_device[s] = dev;
               tag_sector[s] = sec;
               busy_slots[s] = 1'b1;
               valid_slots[s] = 1'b0;
               dirty_slots[s] = 1'b0;
               ans.slot_out = s;
               ans.disk = DISK_READ;
            end
         end
         if (!done) ans = '{slot_out: '0, hit: 1'b0, disk: DISK_NONE, status: STAT_NOBUF};
      end else if (int'(sl) >= LBC_ENTRIES) begin
         ans.status = STAT_NOTBUSY;
      end else if (m == MODE_COMPLETE) begin
         valid_slots[sl] = 1'b1;
         dirty_slots[sl] = 1'b0;
      end else if (!busy_slots[sl]) begin
         ans.status = STAT_NOTBUSY;
      end else if (m == MODE_RELEASE) begin
         move_slot_to_front(sl);
         busy_slots[sl] = 1'b0;
      end else begin
         dirty_slots[sl] = 1'b1;
         ans.disk = DISK_WRITE;
      end
   endtask

   task automatic report_field(input string name, input logic [7:0] exp_v,
                               input logic [7:0] act_v);
      if (exp_v !== act_v) begin
         $display("%0t: response field %s expected %0h actual %0h", $time, name, exp_v,
                  act_v);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         clear_cache_state();
         expected_answers.delete();
      end else begin
         // Responses are handled before requests: a request accepted at this
         // edge cannot be answered at the same edge.
         if (rsp_valid && rsp_ready) begin
            observed = '{slot_out: rsp_slot_out, hit: rsp_hit, disk: rsp_disk_request,
                         status: rsp_status};
            if (expected_answers.size() == 0) begin
               $display("%0t: response with no request waiting, expected none actual %h",
                        $time, observed);
               fail_count++;
            end else begin
               predicted = expected_answers.pop_front();
               report_field("slot_out", 8'(predicted.slot_out), 8'(observed.slot_out));
               report_field("hit", 8'(predicted.hit), 8'(observed.hit));
               report_field("disk_request", 8'(predicted.disk), 8'(observed.disk));
               report_field("status", 8'(predicted.status), 8'(observed.status));
            end
         end
         if (req_valid && req_ready) begin
            predict_answer(req_mode, req_device, req_sector, req_slot, predicted);
            expected_answers.push_back(predicted);
         end
      end
      pending_answers = expected_answers.size();
   end

endmodule

>>> test/tb_lru_block_buffer_cache.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lru_block_buffer_cache
// Drives the buffer cache with a directed opening and then mostly well-formed
// get / write / complete / release traffic, mostly under random back-pressure, while
// the checker predicts and compares every response.
// ----------------------------------------------------------------------------

module tb_lru_block_buffer_cache;
   import lbc_pkg::*;

   localparam int RANDOM_PER_PHASE = 500;
   localparam int CYCLE_LIMIT      = 400000;
   localparam int DRAIN_CYCLES     = 40;

   logic clock;
   logic reset;
   int   src_idle_pct;
   int   snk_idle_pct;
   int   cycle_count;
   int   fail_count;
   int   pending_answers;
   logic [LBC_ENTRIES-1:0] busy_slots;
   logic [LBC_ENTRIES-1:0] dirty_slots;

   logic [DEVICE_W-1:0] device_pool [4] = '{8'h00, 8'hFF, 8'h01, 8'hA5};
   logic [SECTOR_W-1:0] sector_pool [6] = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001,
                                            32'h8000_0000, 32'h0000_0007, 32'h1234_5678};

   lbc_req_if req_ch ();
   lbc_rsp_if rsp_ch ();

   lru_block_buffer_cache DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   lbc_cache_checker checker_inst (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_ch.valid),
      .req_ready        (req_ch.ready),
      .req_mode         (req_ch.mode),
      .req_device       (req_ch.device),
      .req_sector       (req_ch.sector),
      .req_slot         (req_ch.slot),
      .rsp_valid        (rsp_ch.valid),
      .rsp_ready        (rsp_ch.ready),
      .rsp_slot_out     (rsp_ch.slot_out),
      .rsp_hit          (rsp_ch.hit),
      .rsp_disk_request (rsp_ch.disk_request),
      .rsp_status       (rsp_ch.status),
      .fail_count       (fail_count),
      .pending_answers  (pending_answers),
      .busy_slots       (busy_slots),
      .dirty_slots      (dirty_slots)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.mode = MODE_GET;
      req_ch.device = '0;
      req_ch.sector = '0;
      req_ch.slot = '0;
      rsp_ch.ready = 1'b0;
      src_idle_pct = 9;
      snk_idle_pct = 74;
   end

   always @(negedge clock) begin
      rsp_ch.ready <= !reset && ($urandom_range(99) >= snk_idle_pct);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end
   initial cycle_count = 0;

   // Offers one request from a falling edge and returns at the falling edge
   // after it has been accepted.
   task automatic issue_request(input logic [MODE_W-1:0] m, input logic [DEVICE_W-1:0] d,
                                input logic [SECTOR_W-1:0] s, input logic [SLOT_W-1:0] sl);
      while ($urandom_range(99) < src_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.mode <= m;
      req_ch.device <= d;
      req_ch.sector <= s;
      req_ch.slot <= sl;
      @(posedge clock);
      while (req_ch.ready !== 1'b1) @(posedge clock);
      @(negedge clock);
   endtask

   function automatic logic [SLOT_W-1:0] pick_slot_from(input logic [LBC_ENTRIES-1:0] set);
      int count;
      int k;
      logic [SLOT_W-1:0] chosen;
      count = $countones(set);
      k = $urandom_range(count - 1);
      chosen = '0;
      for (int i = 0; i < LBC_ENTRIES; i++) begin
         if (set[i]) begin
            if (k == 0) chosen = SLOT_W'(i);
            k--;
         end
      end
      return chosen;
   endfunction

   // Mostly follows the buffer protocol: release and write go to busy slots,
   // completion often to dirty ones. The rest is noise on random slots.
   task automatic issue_random_request();
      int r;
      logic [MODE_W-1:0]   m;
      logic [DEVICE_W-1:0] d;
      logic [SECTOR_W-1:0] s;
      logic [SLOT_W-1:0]   sl;
      r = $urandom_range(99);
      d = DEVICE_W'($urandom);
      s = SECTOR_W'($urandom);
      sl = SLOT_W'($urandom_range(LBC_ENTRIES - 1));
      if (r < 35) begin
         m = MODE_GET;
         if ($urandom_range(3) != 0) begin
            d = device_pool[$urandom_range(3)];
            s = sector_pool[$urandom_range(5)];
         end
      end else if (r < 65) begin
         m = MODE_RELEASE;
         if (busy_slots != 0 && $urandom_range(9) != 0) sl = pick_slot_from(busy_slots);
      end else if (r < 80) begin
         m = MODE_WRITE;
         if (busy_slots != 0 && $urandom_range(9) > 1) sl = pick_slot_from(busy_slots);
      end else begin
         m = MODE_COMPLETE;
         if (dirty_slots != 0 && $urandom_range(9) > 3) sl = pick_slot_from(dirty_slots);
      end
      issue_request(m, d, s, sl);
   endtask

   initial begin
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed opening: misses, retry on a busy hit, dirty slot, not-busy
      // cases, hits on valid and not-valid slots, then no free buffer.
      issue_request(MODE_GET, 8'h00, 32'h0000_0000, 4'h0);
      issue_request(MODE_GET, 8'hFF, 32'hFFFF_FFFF, 4'hF);
      issue_request(MODE_GET, 8'h00, 32'h0000_0000, 4'h0);
      issue_request(MODE_WRITE, 8'hFF, 32'hFFFF_FFFF, 4'h0);
      issue_request(MODE_RELEASE, 8'h00, 32'h0000_0000, 4'h0);
      issue_request(MODE_RELEASE, 8'h00, 32'h0000_0000, 4'h0);
      issue_request(MODE_WRITE, 8'h00, 32'h0000_0000, 4'h5);
      issue_request(MODE_COMPLETE, 8'h00, 32'h0000_0000, 4'h0);
      issue_request(MODE_GET, 8'h00, 32'h0000_0000, 4'h0);
      issue_request(MODE_RELEASE, 8'h00, 32'h0000_0000, 4'h1);
      issue_request(MODE_GET, 8'hFF, 32'hFFFF_FFFF, 4'h0);
      issue_request(MODE_COMPLETE, 8'hFF, 32'hFFFF_FFFF, 4'hF);
      for (int i = 0; i < LBC_ENTRIES - 1; i++) begin
         issue_request(MODE_GET, 8'hA5, 32'(i), 4'h0);
      end

      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            1: begin
               src_idle_pct = 74;
               snk_idle_pct = 9;
            end
            2: begin
               src_idle_pct = 0;
               snk_idle_pct = 0;
            end
            default: begin
               src_idle_pct = 9;
               snk_idle_pct = 74;
            end
         endcase
         for (int n = 0; n < RANDOM_PER_PHASE; n++) issue_random_request();
      end
      req_ch.valid <= 1'b0;

      while (pending_answers != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && pending_answers == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
